// ===== sv/qlcs_pkg.sv =====
// qlcs_pkg: shared constants and types for the Q-learning channel selector.
// No dependencies; imported by q_learning_channel_selector_core and the verif files.
`timescale 1ns / 1ps
`default_nettype none

package qlcs_pkg;

   // Default sizing
   localparam int DEF_NODES      = 128;
   localparam int DEF_CHANNELS   = 16;
   localparam int DEF_VALUE_BITS = 16;

   // Transaction field widths
   localparam int NEIGHBOUR_W = 7;
   localparam int CHANNEL_W   = 4;
   localparam int METRIC_W    = 8;
   localparam int DRAW_W      = 10;
   localparam int COUNT_W     = 16;

   // Configuration registers
   localparam int LR_W     = 8;
   localparam int MASK_W   = 16;
   localparam int THRESH_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LR_W-1:0]     LR_RESET     = 8'd26;
   localparam logic [MASK_W-1:0]   MASK_RESET   = 16'hFFE5;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd102;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE     = 2'd0,
      CSR_USABLE_MASK       = 2'd1,
      CSR_EXPLORE_THRESHOLD = 2'd2
   } csr_index_type;

   // Reward = metric / 10 in Q8.8, as (m * 6554) >>> 8
   localparam int REWARD_MUL  = 6554;
   localparam int REWARD_MUL_W = 14;
   localparam int REWARD_PROD_W = METRIC_W + 1 + REWARD_MUL_W;
   localparam int REWARD_W    = 13;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// ===== sv/q_learning_channel_selector_core.sv =====
// q_learning_channel_selector_core: epsilon-greedy Q-learning channel selector.
// Depends on qlcs_pkg; holds the value table as an internal synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------------
// req_      | in        | req_valid / req_stall  | neighbour, channel, metric, last_channel,
//           |           |                        | explore_draw, explore_channel
// rsp_      | out       | rsp_valid / rsp_stall  | chosen_channel, explored, dropped,
//           |           |                        | dropped_total
// csr_      | in        | csr_valid / csr_ready  | index, data (register write)
//
// Steps: each transaction passes through three steps (accept + table read, gain multiply,
//   saturate + write back), set by the single read-modify-write of the value table.
// Reset: synchronous; afterwards a clearing pass zeroes the table, one entry per
//   cycle, all NODES*CHANNELS entries (2048 by default), with req_stall held high.
// Stalls: a waiting result sits in the output register while the next transaction
//   is taken; only a last-channel update with the output register still full waits.
// csr_ready is always high; writes are expected only while the block is idle.

module q_learning_channel_selector_core #(
   parameter int NODES      = qlcs_pkg::DEF_NODES,
   parameter int CHANNELS   = qlcs_pkg::DEF_CHANNELS,
   parameter int VALUE_BITS = qlcs_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [qlcs_pkg::NEIGHBOUR_W-1:0]       req_neighbour,
   input  wire logic [qlcs_pkg::CHANNEL_W-1:0]         req_channel,
   input  wire logic signed [qlcs_pkg::METRIC_W-1:0]   req_metric,
   input  wire logic                                   req_last_channel,
   input  wire logic [qlcs_pkg::DRAW_W-1:0]            req_explore_draw,
   input  wire logic [qlcs_pkg::CHANNEL_W-1:0]         req_explore_channel,
   // response
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [qlcs_pkg::CHANNEL_W-1:0]              rsp_chosen_channel,
   output logic                                        rsp_explored,
   output logic                                        rsp_dropped,
   output logic [qlcs_pkg::COUNT_W-1:0]                rsp_dropped_total,
   // configuration
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [qlcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [qlcs_pkg::CSR_DATA_W-1:0]        csr_data
);
   import qlcs_pkg::*;

   localparam int DEPTH = NODES * CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(NODES);
   localparam int CW    = $clog2(CHANNELS);
   localparam int VB    = VALUE_BITS;
   // difference reward - q, wide enough for either operand
   localparam int DW    = ((VB > REWARD_W) ? VB : REWARD_W) + 1;
   localparam int PW    = DW + LR_W + 1;   // gain product
   localparam int SW    = DW + 2;          // q + delta
   localparam logic signed [SW-1:0] Q_MAX = SW'((64'sd1 <<< (VB - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] Q_MIN = -Q_MAX - SW'(1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_MUL   = 4'b0100,
      ST_UPD   = 4'b1000
   } state_type;

   // neighbour modulo NODES by restoring subtraction
   function automatic logic [RW-1:0] row_of(input logic [NEIGHBOUR_W-1:0] n);
      int v;
      v = int'(n);
      for (int k = NEIGHBOUR_W - 1; k >= 0; k--) begin
         if (v >= (NODES << k)) v = v - (NODES << k);
      end
      return RW'(v);
   endfunction

   // channel modulo CHANNELS
   function automatic logic [CW-1:0] chan_of(input logic [CHANNEL_W-1:0] c);
      int v;
      v = int'(c);
      for (int k = CHANNEL_W - 1; k >= 0; k--) begin
         if (v >= (CHANNELS << k)) v = v - (CHANNELS << k);
      end
      return CW'(v);
   endfunction

   // channels past the mask width count as usable
   function automatic logic is_usable(input logic [CW-1:0] c, input logic [MASK_W-1:0] mask);
      int v;
      v = int'(c);
      if (v >= MASK_W) return 1'b1;
      return mask[4'(v)];
   endfunction

   // ---------------------------------------------------------------- config
   logic [LR_W-1:0]     lr_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [THRESH_W-1:0] thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff     <= LR_RESET;
         mask_ff   <= MASK_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEARNING_RATE:     lr_ff     <= csr_data[LR_W-1:0];
            CSR_USABLE_MASK:       mask_ff   <= csr_data[MASK_W-1:0];
            CSR_EXPLORE_THRESHOLD: thresh_ff <= csr_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   state_type state_ff, state_in;
   logic [AW-1:0] clr_addr_ff;
   logic          req_take;
   logic          upd_go;

   logic last_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   // a last-channel update waits only while the output register is full and stalled
   assign upd_go    = !(last_ff && rsp_valid && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:  if (req_take) state_in = ST_MUL;
         ST_MUL:   state_in = ST_UPD;
         ST_UPD:   if (upd_go) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // ---------------------------------------------------------------- accept stage
   logic [RW-1:0] req_row;
   logic [CW-1:0] req_ch;
   logic [AW-1:0] req_addr;
   logic signed [METRIC_W:0]        req_m;
   logic signed [REWARD_PROD_W-1:0] req_rprod;

   assign req_row  = row_of(req_neighbour);
   assign req_ch   = chan_of(req_channel);
   assign req_addr = AW'(req_row * CHANNELS) + AW'(req_ch);
   // penalize unusable channels by one before scaling
   assign req_m     = METRIC_W'(req_metric) - ((is_usable(req_ch, mask_ff)) ? 9'sd0 : 9'sd1);
   assign req_rprod = REWARD_PROD_W'(req_m) * REWARD_PROD_W'(signed'(15'(REWARD_MUL)));

   logic [AW-1:0]               addr_ff;
   logic [CW-1:0]               ch_ff;
   logic [CW-1:0]               ech_ff;
   logic                        explored_ff;
   logic signed [REWARD_W-1:0]  reward_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (req_take) begin
         last_ff <= req_last_channel;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff     <= req_addr;
         ch_ff       <= req_ch;
         ech_ff      <= chan_of(req_explore_channel);
         explored_ff <= ({1'b0, req_explore_draw} < thresh_ff);
         reward_ff   <= req_rprod[REWARD_W+7:8];
      end
   end

   // ---------------------------------------------------------------- value table
   logic [VB-1:0] mem [DEPTH];
   logic [VB-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [VB-1:0] mem_wdata;
   logic signed [VB-1:0] q_new;

   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_UPD) && upd_go);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : q_new;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[req_addr];
   end

   // ---------------------------------------------------------------- gain multiply
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod_ff;
   logic signed [VB-1:0] q_ff;

   assign diff = DW'(reward_ff) - DW'($signed(rd_data_ff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= PW'($signed({1'b0, lr_ff})) * PW'(diff);
         q_ff    <= $signed(rd_data_ff);
      end
   end

   // ---------------------------------------------------------------- update, argmax
   logic signed [SW-1:0] sum;
   assign sum = SW'(q_ff) + SW'(prod_ff >>> 8);

   always_comb begin
      if (sum > Q_MAX)      q_new = Q_MAX[VB-1:0];
      else if (sum < Q_MIN) q_new = Q_MIN[VB-1:0];
      else                  q_new = sum[VB-1:0];
   end

   logic signed [VB-1:0] best_val_ff;
   logic [CW-1:0]        best_ch_ff;
   logic                 take_best;
   logic [CW-1:0]        best_ch_next;
   logic [CW-1:0]        chosen;
   logic                 dropped;
   logic [COUNT_W-1:0]   drop_cnt_ff, drop_cnt_in;

   assign take_best    = (ch_ff == '0) || (q_new > best_val_ff);
   assign best_ch_next = take_best ? ch_ff : best_ch_ff;
   assign chosen       = explored_ff ? ech_ff : best_ch_next;
   assign dropped      = !is_usable(chosen, mask_ff);
   assign drop_cnt_in  = (dropped && (drop_cnt_ff != COUNT_MAX)) ?
                         drop_cnt_ff + COUNT_W'(1) : drop_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_val_ff <= '0;
         best_ch_ff  <= '0;
         drop_cnt_ff <= '0;
      end else if ((state_ff == ST_UPD) && upd_go) begin
         if (take_best) begin
            best_val_ff <= q_new;
            best_ch_ff  <= ch_ff;
         end
         if (last_ff) drop_cnt_ff <= drop_cnt_in;
      end
   end

   // ---------------------------------------------------------------- output register
   logic                 rsp_valid_ff;
   logic [CHANNEL_W-1:0] rsp_chosen_ff;
   logic                 rsp_explored_ff;
   logic                 rsp_dropped_ff;
   logic [COUNT_W-1:0]   rsp_total_ff;
   logic                 rsp_load;

   assign rsp_load = (state_ff == ST_UPD) && upd_go && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chosen_ff   <= CHANNEL_W'(chosen);
         rsp_explored_ff <= explored_ff;
         rsp_dropped_ff  <= dropped;
         rsp_total_ff    <= drop_cnt_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_channel = rsp_chosen_ff;
   assign rsp_explored       = rsp_explored_ff;
   assign rsp_dropped        = rsp_dropped_ff;
   assign rsp_dropped_total  = rsp_total_ff;

endmodule

`default_nettype wire

// ===== verif/channel_choice_checker.sv =====
// channel_choice_checker: watches the request, response and register channels of
// q_learning_channel_selector_core, predicts every channel choice and compares it.
// Depends on qlcs_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

module channel_choice_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic [qlcs_pkg::NEIGHBOUR_W-1:0]     req_neighbour,
   input  wire logic [qlcs_pkg::CHANNEL_W-1:0]       req_channel,
   input  wire logic signed [qlcs_pkg::METRIC_W-1:0] req_metric,
   input  wire logic                                 req_last_channel,
   input  wire logic [qlcs_pkg::DRAW_W-1:0]          req_explore_draw,
   input  wire logic [qlcs_pkg::CHANNEL_W-1:0]       req_explore_channel,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic [qlcs_pkg::CHANNEL_W-1:0]       rsp_chosen_channel,
   input  wire logic                                 rsp_explored,
   input  wire logic                                 rsp_dropped,
   input  wire logic [qlcs_pkg::COUNT_W-1:0]         rsp_dropped_total,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [qlcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [qlcs_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                        mismatches,
   output int                                        choices_waiting
);
   import qlcs_pkg::*;

   localparam int SLOTS     = DEF_NODES * DEF_CHANNELS;
   localparam int VALUE_MAX = (1 << (DEF_VALUE_BITS - 1)) - 1;
   localparam int VALUE_MIN = -(1 << (DEF_VALUE_BITS - 1));

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 explored;
      logic                 dropped;
      logic [COUNT_W-1:0]   total;
   } choice_type;

   logic signed [DEF_VALUE_BITS-1:0] value_mem [0:SLOTS-1];
   int                   best_q;
   logic [CHANNEL_W-1:0] best_ch;
   logic [COUNT_W-1:0]   drop_tally;
   logic [LR_W-1:0]      gain;
   logic [MASK_W-1:0]    usable;
   logic [THRESH_W-1:0]  threshold;
   choice_type           expected_choices [$];

   task automatic learn_metric();
      int                   m;
      int                   reward;
      int                   q;
      int                   nq;
      logic [NEIGHBOUR_W+CHANNEL_W-1:0] slot;
      logic [CHANNEL_W-1:0] pick;
      logic                 take_random;
      choice_type           c;
      slot = {req_neighbour, req_channel};
      m = req_metric;
      if (!usable[req_channel]) m = m - 1;   // penalty on a masked channel
      reward = (m * REWARD_MUL) >>> 8;
      q = value_mem[slot];
      nq = q + ((int'(gain) * (reward - q)) >>> 8);
      if (nq > VALUE_MAX) nq = VALUE_MAX;
      else if (nq < VALUE_MIN) nq = VALUE_MIN;
      value_mem[slot] = nq[DEF_VALUE_BITS-1:0];
      // channel 0 restarts the running max; strict compare keeps the lower channel
      if (req_channel == '0 || nq > best_q) begin
         best_q  = nq;
         best_ch = req_channel;
      end
      if (req_last_channel) begin
         take_random = {1'b0, req_explore_draw} < threshold;
         pick        = take_random ? req_explore_channel : best_ch;
         c.channel   = pick;
         c.explored  = take_random;
         c.dropped   = !usable[pick];
         if (c.dropped && drop_tally != COUNT_MAX) drop_tally = drop_tally + 1'b1;
         c.total = drop_tally;
         expected_choices.push_back(c);
      end
   endtask

   task automatic check_choice();
      choice_type want;
      if (expected_choices.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected response ch=%0d expl=%0d drop=%0d total=%0d",
                     $realtime, rsp_chosen_channel, rsp_explored, rsp_dropped,
                     rsp_dropped_total);
      end else begin
         want = expected_choices.pop_front();
         if (rsp_chosen_channel !== want.channel || rsp_explored !== want.explored ||
             rsp_dropped !== want.dropped || rsp_dropped_total !== want.total) begin
            mismatches++;
            // fields: channel/explored/dropped/total
            if (mismatches <= 10)
               $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        $realtime, want.channel, want.explored, want.dropped, want.total,
                        rsp_chosen_channel, rsp_explored, rsp_dropped, rsp_dropped_total);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) value_mem[i] = '0;
         best_q     = 0;
         best_ch    = '0;
         drop_tally = '0;
         gain       = LR_RESET;
         usable     = MASK_RESET;
         threshold  = THRESH_RESET;
         mismatches = 0;
         expected_choices.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_choice();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEARNING_RATE:     gain      = csr_data[LR_W-1:0];
               CSR_USABLE_MASK:       usable    = csr_data[MASK_W-1:0];
               CSR_EXPLORE_THRESHOLD: threshold = csr_data[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) learn_metric();
      end
      choices_waiting = expected_choices.size();
   end

endmodule

// ===== verif/q_learning_channel_selector_core_test.sv =====
// q_learning_channel_selector_core_test: stimulus and verdict for the channel selector.
// Depends on qlcs_pkg, q_learning_channel_selector_core and channel_choice_checker.
`timescale 1ns / 1ps

module q_learning_channel_selector_core_test;
   import qlcs_pkg::*;

   // Timeout
   localparam int LIMIT     = 1000000;
   // Cycles to let the 3-stage pipeline drain once no choice is pending
   localparam int SETTLE    = 8;
   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   wire logic                  req_stall;
   logic [NEIGHBOUR_W-1:0]     req_neighbour = '0;
   logic [CHANNEL_W-1:0]       req_channel = '0;
   logic signed [METRIC_W-1:0] req_metric = '0;
   logic                       req_last_channel = 1'b0;
   logic [DRAW_W-1:0]          req_explore_draw = '0;
   logic [CHANNEL_W-1:0]       req_explore_channel = '0;

   wire logic                  rsp_valid;
   logic                       rsp_stall = 1'b0;
   wire logic [CHANNEL_W-1:0]  rsp_chosen_channel;
   wire logic                  rsp_explored;
   wire logic                  rsp_dropped;
   wire logic [COUNT_W-1:0]    rsp_dropped_total;

   logic                       csr_valid = 1'b0;
   wire logic                  csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   int  mismatches;
   int  choices_waiting;
   int  cycle_count = 0;
   int  items_sent = 0;
   // quiet: no idle cycles on either side while set
   bit  quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   q_learning_channel_selector_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_neighbour       (req_neighbour),
      .req_channel         (req_channel),
      .req_metric          (req_metric),
      .req_last_channel    (req_last_channel),
      .req_explore_draw    (req_explore_draw),
      .req_explore_channel (req_explore_channel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_chosen_channel  (rsp_chosen_channel),
      .rsp_explored        (rsp_explored),
      .rsp_dropped         (rsp_dropped),
      .rsp_dropped_total   (rsp_dropped_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   channel_choice_checker choice_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_neighbour       (req_neighbour),
      .req_channel         (req_channel),
      .req_metric          (req_metric),
      .req_last_channel    (req_last_channel),
      .req_explore_draw    (req_explore_draw),
      .req_explore_channel (req_explore_channel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_chosen_channel  (rsp_chosen_channel),
      .rsp_explored        (rsp_explored),
      .rsp_dropped         (rsp_dropped),
      .rsp_dropped_total   (rsp_dropped_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatches          (mismatches),
      .choices_waiting     (choices_waiting)
   );

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 60) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Response-side backpressure; stall is held high through each idle run, low otherwise
   initial begin
      int n;
      forever begin
         n = idle_len();
         if (n == 0) begin
            @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   // One request transaction, with an optional idle gap ahead of it.
   // Valid stays high into the next call unless that call opens a gap.
   task automatic send_item(input logic [NEIGHBOUR_W-1:0] nb, input logic [CHANNEL_W-1:0] ch,
                            input logic [METRIC_W-1:0] metric, input logic last,
                            input logic [DRAW_W-1:0] draw, input logic [CHANNEL_W-1:0] ech);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_neighbour       <= nb;
      req_channel         <= ch;
      req_metric          <= metric;
      req_last_channel    <= last;
      req_explore_draw    <= draw;
      req_explore_channel <= ech;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Hold the sender off until every predicted choice is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (choices_waiting != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register writes back to back; valid drops only after the last one
   task automatic program_regs(input logic [CSR_DATA_W-1:0] lr, input logic [CSR_DATA_W-1:0] mask,
                               input logic [CSR_DATA_W-1:0] thr, input bit poke_unmapped);
      logic [CSR_IDX_W-1:0]  idx  [0:3];
      logic [CSR_DATA_W-1:0] val  [0:3];
      int                    n;
      idx[0] = CSR_LEARNING_RATE;     val[0] = lr;
      idx[1] = CSR_USABLE_MASK;       val[1] = mask;
      idx[2] = CSR_EXPLORE_THRESHOLD; val[2] = thr;
      idx[3] = CSR_UNMAPPED;          val[3] = CSR_DATA_W'($urandom);
      n = poke_unmapped ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [METRIC_W-1:0] pick_metric();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h80;                 // most negative
      else if (r == 1) return 8'h7F;            // most positive
      else return METRIC_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [NEIGHBOUR_W-1:0] pick_neighbour();
      // a few hot rows so the table entries actually converge
      if ($urandom_range(0, 9) < 7) return NEIGHBOUR_W'($urandom_range(0, 7));
      return NEIGHBOUR_W'($urandom_range(0, 127));
   endfunction

   // Mostly complete 0..15 sweeps, some partial or unflagged runs, some noise
   task automatic run_random(input int budget);
      int stop_at;
      int kind;
      int first;
      int len;
      bit flag_end;
      logic [NEIGHBOUR_W-1:0] nb;
      bit keep_quiet;
      stop_at = items_sent + budget;
      keep_quiet = quiet;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         nb = pick_neighbour();
         if (!keep_quiet) quiet = ($urandom_range(0, 3) == 0);
         if (kind < 75) begin
            for (int c = 0; c < DEF_CHANNELS; c++)
               send_item(nb, CHANNEL_W'(c), pick_metric(), c == DEF_CHANNELS - 1,
                         DRAW_W'($urandom_range(0, 1023)), CHANNEL_W'($urandom_range(0, 15)));
         end else if (kind < 90) begin
            first    = $urandom_range(0, DEF_CHANNELS - 1);
            len      = $urandom_range(1, DEF_CHANNELS - first);
            flag_end = $urandom_range(0, 1);
            for (int c = first; c < first + len; c++)
               send_item(nb, CHANNEL_W'(c), pick_metric(), flag_end && (c == first + len - 1),
                         DRAW_W'($urandom_range(0, 1023)), CHANNEL_W'($urandom_range(0, 15)));
         end else begin
            send_item(NEIGHBOUR_W'($urandom), CHANNEL_W'($urandom), METRIC_W'($urandom),
                      1'($urandom), DRAW_W'($urandom), CHANNEL_W'($urandom));
         end
         if ($urandom_range(0, 39) == 0) drain();
      end
      quiet = keep_quiet;
   endtask

   task automatic random_regs();
      logic [CSR_DATA_W-1:0] thr;
      thr = CSR_DATA_W'($urandom_range(0, 1024));
      if ($urandom_range(0, 3) == 0) thr = thr | CSR_DATA_W'($urandom_range(0, 31) << THRESH_W);
      program_regs(CSR_DATA_W'($urandom_range(0, 255)), CSR_DATA_W'($urandom_range(0, 65535)),
                   thr, $urandom_range(0, 1));
   endtask

   // Directed sweep metrics: extremes, ties at 127 on usable channels 2, 5, 9, 12, 15
   logic [METRIC_W-1:0] sweep [0:15] = '{8'h80, 8'h7F, 8'h7F, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01,
                                        8'h05, 8'h7F, 8'hCE, 8'h5A, 8'h7F, 8'h80, 8'h00, 8'h7F};

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset register values ---
      // full sweep: ties must resolve to the lowest channel, no exploration
      for (int c = 0; c < DEF_CHANNELS; c++)
         send_item('0, CHANNEL_W'(c), sweep[c], c == DEF_CHANNELS - 1, 10'd1023, '0);
      // draw 0 explores
      send_item(7'd127, 4'd0, 8'h7F, 1'b1, 10'd0, 4'd15);
      // draw just under threshold explores onto a masked channel: drop
      send_item(7'd127, 4'd0, 8'h80, 1'b1, 10'd101, 4'd1);
      // draw equal to threshold is greedy
      send_item(7'd127, 4'd0, 8'h00, 1'b1, 10'd102, 4'd3);
      // streams without channel 0: the running max carries over
      send_item(7'd9, 4'd7, 8'h7F, 1'b1, 10'd1023, 4'd0);
      send_item(7'd9, 4'd3, 8'h80, 1'b0, 10'd1023, 4'd0);
      send_item(7'd9, 4'd4, 8'h80, 1'b1, 10'd1023, 4'd0);

      // --- register extremes ---
      drain();
      program_regs('0, '0, '0, 1'b1);             // no learning, all masked, never explore
      run_random(150);

      drain();
      program_regs(16'd255, 16'hFFFF, 16'd1024, 1'b0);  // full gain, always explore
      quiet = 1'b1;
      run_random(150);
      quiet = 1'b0;

      drain();
      program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1); // upper data bits must be ignored
      run_random(100);

      // --- random register settings ---
      for (int p = 0; p < 4; p++) begin
         drain();
         random_regs();
         run_random(150);
      end

      // back to the reset register values
      drain();
      program_regs(16'd26, 16'hFFE5, 16'd102, 1'b0);
      run_random(100);

      drain();
      if (mismatches == 0 && choices_waiting == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
